// ===== sv/cvm_pkg.sv =====
// Shared types, widths and arithmetic helpers for the cylindrical stress block.
// Used by the channel interfaces and the top-level pipeline; no dependencies.
package cvm_pkg;

    localparam int POS_W           = 32;
    localparam int GRP_W           = 32;
    localparam int STRESS_W        = 32;
    localparam int WIDE_W          = STRESS_W + 4;
    localparam int ANGLE_STEPS     = 16;
    localparam int TRIG_FRAC       = ((61 - STRESS_W) < 30) ? (61 - STRESS_W) : 30;
    localparam int CS_W            = TRIG_FRAC + 3;
    localparam int XY_W            = POS_W + 3;
    localparam int STEPS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = ANGLE_STEPS / STEPS_PER_STAGE;

    localparam int P1_W = STRESS_W + CS_W;
    localparam int S1_W = P1_W + 1;
    localparam int U_W  = S1_W - TRIG_FRAC;
    localparam int P2_W = CS_W + U_W;
    localparam int S2_W = P2_W + 1;
    localparam int R_W  = S2_W - TRIG_FRAC;

    localparam int DIF_W  = STRESS_W + 1;
    localparam int SQ_W   = 2 * DIF_W;
    localparam int ACC_W  = SQ_W + 2;
    localparam int ROOT_W = ACC_W / 2;

    // pipeline stage numbers
    localparam int TRIG_DONE  = CORDIC_STAGES + 5;
    localparam int SQRT_FIRST = 5;
    localparam int LAST       = SQRT_FIRST + ROOT_W - 1;

    localparam logic [GRP_W-1:0] SEL_RESET = GRP_W'(1);
    localparam logic signed [CS_W-1:0] INV_GAIN =
        CS_W'(64'h26DD3B6A >> (30 - TRIG_FRAC));
    localparam logic signed [CS_W-1:0] TRIG_ONE = CS_W'(64'd1 << TRIG_FRAC);
    localparam logic signed [S1_W-1:0] HALF1 = S1_W'(64'd1 << (TRIG_FRAC - 1));
    localparam logic signed [S2_W-1:0] HALF2 = S2_W'(64'd1 << (TRIG_FRAC - 1));

    typedef struct packed {
        logic signed [POS_W-1:0]    pos_x;
        logic signed [POS_W-1:0]    pos_y;
        logic        [GRP_W-1:0]    group_bits;
        logic signed [STRESS_W-1:0] s_xx;
        logic signed [STRESS_W-1:0] s_yy;
        logic signed [STRESS_W-1:0] s_zz;
        logic signed [STRESS_W-1:0] s_xy;
        logic signed [STRESS_W-1:0] s_xz;
        logic signed [STRESS_W-1:0] s_yz;
    } t_in_item;

    typedef struct packed {
        logic signed [WIDE_W-1:0]   radial_stress;
        logic signed [WIDE_W-1:0]   hoop_stress;
        logic signed [STRESS_W-1:0] axial_stress;
        logic signed [WIDE_W-1:0]   radial_hoop_shear;
        logic signed [WIDE_W-1:0]   radial_axial_shear;
        logic signed [WIDE_W-1:0]   hoop_axial_shear;
        logic        [WIDE_W-1:0]   von_mises;
    } t_out_item;

    typedef struct packed {
        logic signed [STRESS_W-1:0] sxx;
        logic signed [STRESS_W-1:0] syy;
        logic signed [STRESS_W-1:0] szz;
        logic signed [STRESS_W-1:0] sxy;
        logic signed [STRESS_W-1:0] sxz;
        logic signed [STRESS_W-1:0] syz;
    } t_str;

    typedef struct packed {
        logic signed [XY_W-1:0] px;
        logic signed [XY_W-1:0] py;
        logic signed [CS_W-1:0] c;
        logic signed [CS_W-1:0] s;
    } t_cd;

    typedef struct packed {
        logic hit;
        logic flip;
        logic org;
    } t_flag;

    typedef struct packed {
        logic signed [P1_W-1:0] xxc;
        logic signed [P1_W-1:0] xys;
        logic signed [P1_W-1:0] xyc;
        logic signed [P1_W-1:0] yys;
        logic signed [P1_W-1:0] xxs;
        logic signed [P1_W-1:0] yyc;
        logic signed [P1_W-1:0] xzc;
        logic signed [P1_W-1:0] yzs;
        logic signed [P1_W-1:0] yzc;
        logic signed [P1_W-1:0] xzs;
    } t_p1;

    typedef struct packed {
        logic signed [U_W-1:0] uxr;
        logic signed [U_W-1:0] uyr;
        logic signed [U_W-1:0] uxt;
        logic signed [U_W-1:0] uyt;
        logic signed [U_W-1:0] rz;
        logic signed [U_W-1:0] tz;
    } t_u;

    typedef struct packed {
        logic signed [P2_W-1:0] cuxr;
        logic signed [P2_W-1:0] suyr;
        logic signed [P2_W-1:0] cuyt;
        logic signed [P2_W-1:0] suxt;
        logic signed [P2_W-1:0] cuxt;
        logic signed [P2_W-1:0] suyt;
    } t_p2;

    typedef struct packed {
        logic signed [WIDE_W-1:0]   rr;
        logic signed [WIDE_W-1:0]   tt;
        logic signed [WIDE_W-1:0]   rt;
        logic signed [WIDE_W-1:0]   rz;
        logic signed [WIDE_W-1:0]   tz;
        logic signed [STRESS_W-1:0] zz;
        logic                       hit;
    } t_res;

    typedef struct packed {
        logic signed [DIF_W-1:0]    d1;
        logic signed [DIF_W-1:0]    d2;
        logic signed [DIF_W-1:0]    d3;
        logic signed [STRESS_W-1:0] xy;
        logic signed [STRESS_W-1:0] xz;
        logic signed [STRESS_W-1:0] yz;
    } t_dif;

    typedef struct packed {
        logic [SQ_W-1:0] q1;
        logic [SQ_W-1:0] q2;
        logic [SQ_W-1:0] q3;
        logic [SQ_W-1:0] q4;
        logic [SQ_W-1:0] q5;
        logic [SQ_W-1:0] q6;
    } t_sqr;

    typedef struct packed {
        logic [ROOT_W+1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [ACC_W-1:0]  v;
    } t_sq;

    // two vectoring micro-rotations, the first by atan(2^-i0)
    function automatic t_cd f_cordic2(t_cd a, int unsigned i0);
        t_cd b;
        logic signed [XY_W-1:0] nx, ny;
        logic signed [CS_W-1:0] nc, ns;
        b = a;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            if (!b.py[XY_W-1]) begin
                nx = b.px + (b.py >>> (i0 + k));
                ny = b.py - (b.px >>> (i0 + k));
                nc = b.c - (b.s >>> (i0 + k));
                ns = b.s + (b.c >>> (i0 + k));
            end else begin
                nx = b.px - (b.py >>> (i0 + k));
                ny = b.py + (b.px >>> (i0 + k));
                nc = b.c + (b.s >>> (i0 + k));
                ns = b.s - (b.c >>> (i0 + k));
            end
            b.px = nx;
            b.py = ny;
            b.c  = nc;
            b.s  = ns;
        end
        return b;
    endfunction

    // round to nearest, ties up, and drop the trig fraction
    function automatic logic signed [U_W-1:0] f_rnd1(logic signed [S1_W-1:0] v);
        logic signed [S1_W-1:0] t;
        t = v + HALF1;
        return t[S1_W-1:TRIG_FRAC];
    endfunction

    function automatic logic signed [R_W-1:0] f_rnd2(logic signed [S2_W-1:0] v);
        logic signed [S2_W-1:0] t;
        t = v + HALF2;
        return t[S2_W-1:TRIG_FRAC];
    endfunction

    function automatic logic signed [WIDE_W-1:0] f_sat(logic signed [R_W-1:0] v);
        logic [R_W-WIDE_W:0] top;
        top = v[R_W-1:WIDE_W-1];
        if (top == '0 || top == '1) begin
            return v[WIDE_W-1:0];
        end else if (v[R_W-1]) begin
            return {1'b1, {(WIDE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(WIDE_W-1){1'b1}}};
        end
    endfunction

    // one result bit of the digit-by-digit square root
    function automatic t_sq f_sqstep(t_sq a);
        t_sq b;
        logic [ROOT_W+1:0] r2, trial;
        r2    = {a.rem[ROOT_W-1:0], a.v[ACC_W-1 -: 2]};
        trial = {a.root, 2'b01};
        if (r2 >= trial) begin
            b.rem  = r2 - trial;
            b.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            b.rem  = r2;
            b.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        b.v = {a.v[ACC_W-3:0], 2'b00};
        return b;
    endfunction

endpackage

// ===== sv/cvm_in_if.sv =====
// Particle input channel: valid/ready handshake with one particle per beat.
// Depends on cvm_pkg for the payload type.
interface cvm_in_if;
    import cvm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/cvm_out_if.sv =====
// Result channel: valid/ready handshake with one stress result per beat.
// Depends on cvm_pkg for the payload type.
interface cvm_out_if;
    import cvm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/cvm_cfg_if.sv =====
// Configuration write channel carrying the group select mask.
// Depends on cvm_pkg for the data width.
interface cvm_cfg_if;
    import cvm_pkg::*;
    logic             valid;
    logic             ready;
    logic [GRP_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/cylindrical_stress_and_von_mises.sv =====
// Cylindrical stress rotation and von Mises stress, fully pipelined.
// Throughput one particle per cycle while the output is not stalled. The CORDIC
// (two micro-rotations a stage) runs alongside the one-bit-a-stage square root,
// which sets the depth. A stalled output freezes every stage in place.
// Reset clears all valid bits and loads group_select with 1.
module cylindrical_stress_and_von_mises (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cvm_in_if.sink      i_in,
    cvm_cfg_if.sink     i_cfg,
    cvm_out_if.source   o_out
);
    import cvm_pkg::*;

    logic [GRP_W-1:0] r_sel;
    logic [LAST:0]    r_vld;
    logic             w_en;

    logic signed [XY_W-1:0] w_px, w_py;
    logic                   w_flip, w_org, w_hit;

    t_cd   r_cd  [0:CORDIC_STAGES];
    t_str  r_cst [0:CORDIC_STAGES];
    t_flag r_cfl [0:CORDIC_STAGES];

    logic signed [CS_W-1:0] r_c9, r_s9, r_c10, r_s10, r_c11, r_s11;
    t_str                   r_str9;
    logic                   r_hit9, r_hit10, r_hit11, r_hit12;
    logic signed [STRESS_W-1:0] r_zz10, r_zz11, r_zz12;
    t_p1                    r_p1;
    t_u                     r_u;
    t_p2                    r_p2;
    logic signed [U_W-1:0]  r_rz12, r_tz12;
    t_res                   r_res [TRIG_DONE:LAST];

    t_dif             r_d;
    t_sqr             r_q;
    logic [ACC_W-1:0] r_n, r_h, r_rad, w_tot;
    t_sq              r_sq [SQRT_FIRST:LAST];

    // the whole pipeline advances unless a finished result waits
    assign w_en        = !r_vld[LAST] || o_out.ready;
    assign i_in.ready  = w_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= SEL_RESET;
        end else if (i_cfg.valid) begin
            r_sel <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], i_in.valid};
        end
    end

    // fold the left half plane onto the right one
    always_comb begin
        w_flip = i_in.data.pos_x[POS_W-1];
        w_org  = (i_in.data.pos_x == '0) && (i_in.data.pos_y == '0);
        w_hit  = |(i_in.data.group_bits & r_sel);
        w_px   = XY_W'(i_in.data.pos_x);
        w_py   = XY_W'(i_in.data.pos_y);
        if (w_flip) begin
            w_px = -w_px;
            w_py = -w_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cd[0]  <= '{px: w_px, py: w_py, c: INV_GAIN, s: '0};
            r_cst[0] <= '{sxx: i_in.data.s_xx, syy: i_in.data.s_yy,
                          szz: i_in.data.s_zz, sxy: i_in.data.s_xy,
                          sxz: i_in.data.s_xz, syz: i_in.data.s_yz};
            r_cfl[0] <= '{hit: w_hit, flip: w_flip, org: w_org};
        end
    end

    for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cd[k]  <= f_cordic2(r_cd[k-1], (k - 1) * STEPS_PER_STAGE);
                r_cst[k] <= r_cst[k-1];
                r_cfl[k] <= r_cfl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage: undo the fold, force angle zero at the origin
            if (r_cfl[CORDIC_STAGES].org) begin
                r_c9 <= TRIG_ONE;
                r_s9 <= '0;
            end else if (r_cfl[CORDIC_STAGES].flip) begin
                r_c9 <= -r_cd[CORDIC_STAGES].c;
                r_s9 <= -r_cd[CORDIC_STAGES].s;
            end else begin
                r_c9 <= r_cd[CORDIC_STAGES].c;
                r_s9 <= r_cd[CORDIC_STAGES].s;
            end
            r_str9 <= r_cst[CORDIC_STAGES];
            r_hit9 <= r_cfl[CORDIC_STAGES].hit;

            // stage: S times the basis vectors, products
            r_p1.xxc <= r_str9.sxx * r_c9;
            r_p1.xys <= r_str9.sxy * r_s9;
            r_p1.xyc <= r_str9.sxy * r_c9;
            r_p1.yys <= r_str9.syy * r_s9;
            r_p1.xxs <= r_str9.sxx * r_s9;
            r_p1.yyc <= r_str9.syy * r_c9;
            r_p1.xzc <= r_str9.sxz * r_c9;
            r_p1.yzs <= r_str9.syz * r_s9;
            r_p1.yzc <= r_str9.syz * r_c9;
            r_p1.xzs <= r_str9.sxz * r_s9;
            r_c10    <= r_c9;
            r_s10    <= r_s9;
            r_zz10   <= r_str9.szz;
            r_hit10  <= r_hit9;

            // stage: sums and rounding
            r_u.uxr <= f_rnd1(S1_W'(r_p1.xxc) + S1_W'(r_p1.xys));
            r_u.uyr <= f_rnd1(S1_W'(r_p1.xyc) + S1_W'(r_p1.yys));
            r_u.uxt <= f_rnd1(S1_W'(r_p1.xyc) - S1_W'(r_p1.xxs));
            r_u.uyt <= f_rnd1(S1_W'(r_p1.yyc) - S1_W'(r_p1.xys));
            r_u.rz  <= f_rnd1(S1_W'(r_p1.xzc) + S1_W'(r_p1.yzs));
            r_u.tz  <= f_rnd1(S1_W'(r_p1.yzc) - S1_W'(r_p1.xzs));
            r_c11   <= r_c10;
            r_s11   <= r_s10;
            r_zz11  <= r_zz10;
            r_hit11 <= r_hit10;

            // stage: projection on the basis vectors, products
            r_p2.cuxr <= r_c11 * r_u.uxr;
            r_p2.suyr <= r_s11 * r_u.uyr;
            r_p2.cuyt <= r_c11 * r_u.uyt;
            r_p2.suxt <= r_s11 * r_u.uxt;
            r_p2.cuxt <= r_c11 * r_u.uxt;
            r_p2.suyt <= r_s11 * r_u.uyt;
            r_rz12    <= r_u.rz;
            r_tz12    <= r_u.tz;
            r_zz12    <= r_zz11;
            r_hit12   <= r_hit11;

            // stage: sums, rounding, saturation
            r_res[TRIG_DONE].rr  <= f_sat(f_rnd2(S2_W'(r_p2.cuxr) + S2_W'(r_p2.suyr)));
            r_res[TRIG_DONE].tt  <= f_sat(f_rnd2(S2_W'(r_p2.cuyt) - S2_W'(r_p2.suxt)));
            r_res[TRIG_DONE].rt  <= f_sat(f_rnd2(S2_W'(r_p2.cuxt) + S2_W'(r_p2.suyt)));
            r_res[TRIG_DONE].rz  <= f_sat(R_W'(r_rz12));
            r_res[TRIG_DONE].tz  <= f_sat(R_W'(r_tz12));
            r_res[TRIG_DONE].zz  <= r_zz12;
            r_res[TRIG_DONE].hit <= r_hit12;
        end
    end

    for (genvar k = TRIG_DONE + 1; k <= LAST; k++) begin : g_delay
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_res[k] <= r_res[k-1];
            end
        end
    end

    // von Mises: differences, squares, sums, then the root
    assign w_tot = r_n + (r_h << 1) + (r_h << 2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d.d1 <= DIF_W'(r_cst[0].sxx) - DIF_W'(r_cst[0].syy);
            r_d.d2 <= DIF_W'(r_cst[0].syy) - DIF_W'(r_cst[0].szz);
            r_d.d3 <= DIF_W'(r_cst[0].szz) - DIF_W'(r_cst[0].sxx);
            r_d.xy <= r_cst[0].sxy;
            r_d.xz <= r_cst[0].sxz;
            r_d.yz <= r_cst[0].syz;

            r_q.q1 <= r_d.d1 * r_d.d1;
            r_q.q2 <= r_d.d2 * r_d.d2;
            r_q.q3 <= r_d.d3 * r_d.d3;
            r_q.q4 <= r_d.xy * r_d.xy;
            r_q.q5 <= r_d.xz * r_d.xz;
            r_q.q6 <= r_d.yz * r_d.yz;

            r_n <= ACC_W'(r_q.q1) + ACC_W'(r_q.q2) + ACC_W'(r_q.q3);
            r_h <= ACC_W'(r_q.q4) + ACC_W'(r_q.q5) + ACC_W'(r_q.q6);

            r_rad <= w_tot >> 1;

            r_sq[SQRT_FIRST] <= f_sqstep('{rem: '0, root: '0, v: r_rad});
        end
    end

    for (genvar k = SQRT_FIRST + 1; k <= LAST; k++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq[k] <= f_sqstep(r_sq[k-1]);
            end
        end
    end

    // zero the result data for a particle outside the selected group; the beat stays valid
    always_comb begin
        o_out.valid = r_vld[LAST];
        if (r_res[LAST].hit) begin
            o_out.data.radial_stress      = r_res[LAST].rr;
            o_out.data.hoop_stress        = r_res[LAST].tt;
            o_out.data.axial_stress       = r_res[LAST].zz;
            o_out.data.radial_hoop_shear  = r_res[LAST].rt;
            o_out.data.radial_axial_shear = r_res[LAST].rz;
            o_out.data.hoop_axial_shear   = r_res[LAST].tz;
            o_out.data.von_mises          = WIDE_W'(r_sq[LAST].root);
        end else begin
            o_out.data = '0;
        end
    end

    localparam logic signed [CS_W-1:0] C_LIM = TRIG_ONE + (TRIG_ONE >>> 8);

    a_stall_only_on_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without a held result");

    a_accept_enters_pipeline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted beat lost at entry");

    a_trig_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[CORDIC_STAGES+1] |->
            (r_c9 <= C_LIM && r_c9 >= -C_LIM && r_s9 <= C_LIM && r_s9 >= -C_LIM))
        else $error("cos/sin out of range after CORDIC");

endmodule
